### hdl/vrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_pkg: shared types and constants
// Item, configuration and angle-fold definitions for the vertex rotate and
// project engine, plus the quarter-wave sine table.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERSPECTIVE_ON = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Z         = 3'd7;

    localparam int COORD_W  = 16;
    localparam int ANG_W    = 9;
    localparam int ROT_W    = 18;
    localparam int SCALE_W  = 12;
    localparam int CENTER_W = 12;
    localparam int DIST_W   = 16;
    localparam int SCR_W    = 16;
    localparam int TBL_W    = 15;
    localparam int TBL_FRAC = 14;

    localparam logic [SCALE_W-1:0]  RST_SCREEN_SCALE  = 12'd250;
    localparam logic [CENTER_W-1:0] RST_CENTER_X      = 12'd400;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y      = 12'd300;
    localparam logic [DIST_W-1:0]   RST_VIEW_DISTANCE = 16'd8192;
    localparam logic [ANG_W-1:0]    RST_STEP          = 9'd1;

    localparam logic [9:0] QTR_TURN   = 10'd90;
    localparam logic [9:0] HALF_TURN  = 10'd180;
    localparam logic [9:0] THREE_QTR  = 10'd270;
    localparam logic [9:0] FULL_TURN  = 10'd360;
    localparam logic [9:0] TWO_TURNS  = 10'd720;

    localparam logic [TBL_W-1:0] QSIN [91] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
        15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
        15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
        15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
        15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
        15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    typedef struct packed {
        logic [SCALE_W-1:0]  screen_scale;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [DIST_W-1:0]   view_distance;
        logic                perspective_on;
        logic [ANG_W-1:0]    step_x;
        logic [ANG_W-1:0]    step_y;
        logic [ANG_W-1:0]    step_z;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ANG_W-1:0]          ang_x;
        logic [ANG_W-1:0]          ang_y;
        logic [ANG_W-1:0]          ang_z;
    } t_item;

    typedef struct packed {
        logic [6:0] idx;
        logic       neg;
    } t_fold;

    // Map an angle below 450 degrees onto the quarter-wave table.
    function automatic t_fold fold_angle(input logic [9:0] a_in);
        logic [9:0] a;
        t_fold      f;
        a = (a_in >= FULL_TURN) ? a_in - FULL_TURN : a_in;
        if (a <= QTR_TURN) begin
            f.idx = a[6:0];
            f.neg = 1'b0;
        end else if (a <= HALF_TURN) begin
            f.idx = 7'(HALF_TURN - a);
            f.neg = 1'b0;
        end else if (a <= THREE_QTR) begin
            f.idx = 7'(a - HALF_TURN);
            f.neg = 1'b1;
        end else begin
            f.idx = 7'(FULL_TURN - a);
            f.neg = 1'b1;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

### hdl/vrp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_in_if: input item channel
// Valid/ready channel carrying an operation code and one vertex.
// ----------------------------------------------------------------------------
interface vrp_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;

    modport source (output valid, operation, vertex_x, vertex_y, vertex_z, input ready);
    modport sink   (input valid, operation, vertex_x, vertex_y, vertex_z, output ready);
endinterface
`default_nettype wire

### hdl/vrp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_out_if: result channel
// Valid/ready channel carrying screen coordinates and the clip flag.
// ----------------------------------------------------------------------------
interface vrp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               clipped;

    modport source (output valid, screen_x, screen_y, clipped, input ready);
    modport sink   (input valid, screen_x, screen_y, clipped, output ready);
endinterface
`default_nettype wire

### hdl/vrp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_front: item intake
// Accepts items, advances the frame angles on a tick and tags each vertex
// with the angles current at its transfer before queuing it.
// ----------------------------------------------------------------------------
module vrp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vrp_in_if.sink         i_item,
    input  vrp_pkg::t_cfg  i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output vrp_pkg::t_item o_item
);
    import vrp_pkg::*;

    logic [ANG_W-1:0] r_ang_x, r_ang_y, r_ang_z;
    logic             w_accept;

    function automatic logic [ANG_W-1:0] step_angle(input logic [ANG_W-1:0] a,
                                                   input logic [ANG_W-1:0] s);
        logic [9:0] sum;
        sum = {1'b0, a} + {1'b0, s};
        if (sum >= TWO_TURNS) begin
            sum = sum - TWO_TURNS;
        end else if (sum >= FULL_TURN) begin
            sum = sum - FULL_TURN;
        end
        return sum[ANG_W-1:0];
    endfunction

    assign i_item.ready = !i_full;
    assign w_accept     = i_item.valid && i_item.ready;
    assign o_push       = w_accept && (i_item.operation == OP_VERTEX);

    always_comb begin
        o_item.x     = i_item.vertex_x;
        o_item.y     = i_item.vertex_y;
        o_item.z     = i_item.vertex_z;
        o_item.ang_x = r_ang_x;
        o_item.ang_y = r_ang_y;
        o_item.ang_z = r_ang_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x <= '0;
            r_ang_y <= '0;
            r_ang_z <= '0;
        end else if (w_accept && (i_item.operation == OP_TICK)) begin
            r_ang_x <= step_angle(r_ang_x, i_cfg.step_x);
            r_ang_y <= step_angle(r_ang_y, i_cfg.step_y);
            r_ang_z <= step_angle(r_ang_z, i_cfg.step_z);
        end
    end

endmodule
`default_nettype wire

### hdl/vrp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_queue: vertex queue
// Four-entry FIFO between the intake and the transform pipeline.
// ----------------------------------------------------------------------------
module vrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vrp_pkg::t_item i_data,
    input  logic           i_pop,
    output vrp_pkg::t_item o_data,
    output logic           o_full,
    output logic           o_empty
);
    import vrp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = 2;

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/vrp_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_rotate: Euler rotation pipeline
// Looks up sine and cosine for the three tagged angles, then rotates about
// Y, X and Z, one multiply stage and one round stage per axis.
// ----------------------------------------------------------------------------
module vrp_rotate #(
    parameter int TF = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  vrp_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    output logic signed [vrp_pkg::ROT_W-1:0]  o_x,
    output logic signed [vrp_pkg::ROT_W-1:0]  o_y,
    output logic signed [vrp_pkg::ROT_W-1:0]  o_z
);
    import vrp_pkg::*;

    localparam int TW    = TF + 2;
    localparam int PW    = ROT_W + TW;
    localparam int SW    = PW + 1;
    localparam int SH_UP = (TF >= TBL_FRAC) ? TF - TBL_FRAC : 0;
    localparam int SH_DN = (TF < TBL_FRAC) ? TBL_FRAC - TF : 0;
    localparam logic [31:0] TBL_HALF = 32'(1 << SH_DN) >> 1;
    localparam logic [SW-1:0] RND_HALF = SW'(1) << (TF - 1);

    function automatic logic signed [TW-1:0] trig_val(input logic [9:0] a);
        t_fold                  f;
        logic [31:0]            t;
        logic signed [TW-1:0]   v;
        f = fold_angle(a);
        t = 32'(QSIN[f.idx]) + TBL_HALF;
        t = (t >> SH_DN) << SH_UP;
        v = $signed({1'b0, t[TF:0]});
        return f.neg ? -v : v;
    endfunction

    function automatic logic signed [ROT_W-1:0] rnd(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = v[SW-1] ? SW'(-v) : SW'(v);
        m = (m + RND_HALF) >> TF;
        return v[SW-1] ? ROT_W'(-m) : ROT_W'(m);
    endfunction

    logic [6:0] r_v;

    logic signed [ROT_W-1:0] r0_x, r0_y, r0_z;
    logic signed [TW-1:0]    r0_cy, r0_sy, r0_cx, r0_sx, r0_cz, r0_sz;
    logic signed [PW-1:0]    r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [ROT_W-1:0] r1_y;
    logic signed [TW-1:0]    r1_cx, r1_sx, r1_cz, r1_sz;
    logic signed [ROT_W-1:0] r2_x, r2_y, r2_z;
    logic signed [TW-1:0]    r2_cx, r2_sx, r2_cz, r2_sz;
    logic signed [PW-1:0]    r3_pa, r3_pb, r3_pc, r3_pd;
    logic signed [ROT_W-1:0] r3_x;
    logic signed [TW-1:0]    r3_cz, r3_sz;
    logic signed [ROT_W-1:0] r4_x, r4_y, r4_z;
    logic signed [TW-1:0]    r4_cz, r4_sz;
    logic signed [PW-1:0]    r5_pa, r5_pb, r5_pc, r5_pd;
    logic signed [ROT_W-1:0] r5_z;
    logic signed [ROT_W-1:0] r6_x, r6_y, r6_z;

    assign o_pop   = i_adv && i_valid;
    assign o_valid = r_v[6];
    assign o_x     = r6_x;
    assign o_y     = r6_y;
    assign o_z     = r6_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // trig lookup
            r0_x  <= ROT_W'(i_item.x);
            r0_y  <= ROT_W'(i_item.y);
            r0_z  <= ROT_W'(i_item.z);
            r0_sy <= trig_val({1'b0, i_item.ang_y});
            r0_cy <= trig_val({1'b0, i_item.ang_y} + QTR_TURN);
            r0_sx <= trig_val({1'b0, i_item.ang_x});
            r0_cx <= trig_val({1'b0, i_item.ang_x} + QTR_TURN);
            r0_sz <= trig_val({1'b0, i_item.ang_z});
            r0_cz <= trig_val({1'b0, i_item.ang_z} + QTR_TURN);
            // rotate about Y
            r1_pa <= r0_cy * r0_x;
            r1_pb <= r0_sy * r0_z;
            r1_pc <= r0_cy * r0_z;
            r1_pd <= r0_sy * r0_x;
            r1_y  <= r0_y;
            r1_cx <= r0_cx;
            r1_sx <= r0_sx;
            r1_cz <= r0_cz;
            r1_sz <= r0_sz;
            r2_x  <= rnd(SW'(r1_pa) + SW'(r1_pb));
            r2_z  <= rnd(SW'(r1_pc) - SW'(r1_pd));
            r2_y  <= r1_y;
            r2_cx <= r1_cx;
            r2_sx <= r1_sx;
            r2_cz <= r1_cz;
            r2_sz <= r1_sz;
            // rotate about X
            r3_pa <= r2_cx * r2_y;
            r3_pb <= r2_sx * r2_z;
            r3_pc <= r2_sx * r2_y;
            r3_pd <= r2_cx * r2_z;
            r3_x  <= r2_x;
            r3_cz <= r2_cz;
            r3_sz <= r2_sz;
            r4_y  <= rnd(SW'(r3_pa) - SW'(r3_pb));
            r4_z  <= rnd(SW'(r3_pc) + SW'(r3_pd));
            r4_x  <= r3_x;
            r4_cz <= r3_cz;
            r4_sz <= r3_sz;
            // rotate about Z
            r5_pa <= r4_cz * r4_x;
            r5_pb <= r4_sz * r4_y;
            r5_pc <= r4_sz * r4_x;
            r5_pd <= r4_cz * r4_y;
            r5_z  <= r4_z;
            r6_x  <= rnd(SW'(r5_pa) - SW'(r5_pb));
            r6_y  <= rnd(SW'(r5_pc) + SW'(r5_pd));
            r6_z  <= r5_z;
        end
    end

endmodule
`default_nettype wire

### hdl/vrp_project.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrp_project: projection and screen mapping
// Forms the depth divisor, scales x and y, divides both through a
// restoring divider one quotient bit per stage, adds the screen center
// and saturates. Orthographic mode divides by a fixed power of two.
// ----------------------------------------------------------------------------
module vrp_project #(
    parameter int CF = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [vrp_pkg::ROT_W-1:0]  i_x,
    input  logic signed [vrp_pkg::ROT_W-1:0]  i_y,
    input  logic signed [vrp_pkg::ROT_W-1:0]  i_z,
    input  vrp_pkg::t_cfg                     i_cfg,
    vrp_out_if.source                         o_result,
    output logic                              o_adv
);
    import vrp_pkg::*;

    localparam int QB  = 19;
    localparam int DW  = DIST_W + CF + 2;
    localparam int NAW = ROT_W + SCALE_W + 1;
    localparam int NW  = 47;
    localparam int RW0 = (NW > DW - 1 + QB) ? NW : DW - 1 + QB;
    localparam int RW  = RW0 + 1;
    localparam int VW  = QB + 2;
    localparam logic signed [VW-1:0] SAT_MAX = VW'(32767);
    localparam logic signed [VW-1:0] SAT_MIN = -VW'(32768);
    localparam logic signed [SCR_W-1:0] SCR_MAX = 16'sh7FFF;
    localparam logic signed [SCR_W-1:0] SCR_MIN = 16'sh8000;

    typedef struct packed {
        logic bad;
        logic xneg;
        logic yneg;
        logic ovx;
        logic ovy;
    } t_side;

    // stage 0
    logic                   r0_v, r0_xneg, r0_yneg;
    logic signed [DW-1:0]   r0_den;
    logic signed [NAW-1:0]  r0_na, r0_nb;
    logic signed [DW-1:0]   w_den;
    // stage 1
    logic                   r1_v, r1_bad, r1_xneg, r1_yneg;
    logic [DW-2:0]          r1_d;
    logic [NW-1:0]          r1_mx, r1_my;
    // divider
    logic [RW-1:0]          r_rx [QB+1];
    logic [RW-1:0]          r_ry [QB+1];
    logic [QB-1:0]          r_qx [QB+1];
    logic [QB-1:0]          r_qy [QB+1];
    logic [DW-2:0]          r_d  [QB+1];
    t_side                  r_sd [QB+1];
    logic                   r_sv [QB+1];
    // output
    logic                   r_out_valid, r_clip;
    logic signed [SCR_W-1:0] r_sx, r_sy;

    function automatic logic [NAW-1:0] mag(input logic signed [NAW-1:0] v);
        return v[NAW-1] ? NAW'(-v) : NAW'(v);
    endfunction

    function automatic logic signed [SCR_W-1:0] sat(input logic signed [VW-1:0] v,
                                                    output logic hit);
        hit = 1'b0;
        if (v > SAT_MAX) begin
            hit = 1'b1;
            return SCR_MAX;
        end else if (v < SAT_MIN) begin
            hit = 1'b1;
            return SCR_MIN;
        end
        return SCR_W'(v);
    endfunction

    assign o_adv = !r_out_valid || o_result.ready;

    always_comb begin
        if (i_cfg.perspective_on) begin
            w_den = $signed({2'b00, i_cfg.view_distance, {CF{1'b0}}})
                  - (DW'(i_z) <<< 12);
        end else begin
            w_den = DW'(1) <<< (CF + 12);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (o_adv) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r0_den  <= w_den;
            r0_na   <= i_x * $signed({1'b0, i_cfg.screen_scale});
            r0_nb   <= i_y * $signed({1'b0, i_cfg.screen_scale});
            r0_xneg <= i_x[ROT_W-1];
            r0_yneg <= i_y[ROT_W-1];

            // fold the rounding half of the divisor into the dividend
            r1_bad  <= r0_den[DW-1] || (r0_den == '0);
            r1_d    <= (r0_den[DW-1] || (r0_den == '0)) ? (DW-1)'(1) : r0_den[DW-2:0];
            r1_mx   <= (NW'(mag(r0_na)) << 16) + NW'(r0_den[DW-2:1]);
            r1_my   <= (NW'(mag(r0_nb)) << 16) + NW'(r0_den[DW-2:1]);
            r1_xneg <= r0_xneg;
            r1_yneg <= r0_yneg;
        end
    end

    // seed stage: quotient range check, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (o_adv) begin
            r_sv[0] <= r1_v;
            for (int k = 0; k < QB; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_rx[0]      <= RW'(r1_mx);
            r_ry[0]      <= RW'(r1_my);
            r_qx[0]      <= '0;
            r_qy[0]      <= '0;
            r_d[0]       <= r1_d;
            r_sd[0].bad  <= r1_bad;
            r_sd[0].xneg <= r1_xneg;
            r_sd[0].yneg <= r1_yneg;
            r_sd[0].ovx  <= RW'(r1_mx) >= (RW'(r1_d) << QB);
            r_sd[0].ovy  <= RW'(r1_my) >= (RW'(r1_d) << QB);
            for (int k = 0; k < QB; k++) begin
                if (r_rx[k] >= (RW'(r_d[k]) << (QB - 1 - k))) begin
                    r_rx[k+1] <= r_rx[k] - (RW'(r_d[k]) << (QB - 1 - k));
                    r_qx[k+1] <= r_qx[k] | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_rx[k+1] <= r_rx[k];
                    r_qx[k+1] <= r_qx[k];
                end
                if (r_ry[k] >= (RW'(r_d[k]) << (QB - 1 - k))) begin
                    r_ry[k+1] <= r_ry[k] - (RW'(r_d[k]) << (QB - 1 - k));
                    r_qy[k+1] <= r_qy[k] | (QB'(1) << (QB - 1 - k));
                end else begin
                    r_ry[k+1] <= r_ry[k];
                    r_qy[k+1] <= r_qy[k];
                end
                r_d[k+1]       <= r_d[k];
                r_sd[k+1].bad  <= r_sd[k].bad;
                r_sd[k+1].xneg <= r_sd[k].xneg;
                r_sd[k+1].yneg <= r_sd[k].yneg;
                r_sd[k+1].ovx  <= r_sd[k].ovx;
                r_sd[k+1].ovy  <= r_sd[k].ovy;
            end
        end
    end

    // sign, center offset and saturation
    always_ff @(posedge i_clk) begin
        logic signed [VW-1:0] vx, vy;
        logic                 hx, hy;
        logic signed [SCR_W-1:0] sx, sy;
        vx = (r_sd[QB].xneg ? -$signed({2'b00, r_qx[QB]}) : $signed({2'b00, r_qx[QB]}))
           + $signed(VW'({i_cfg.center_x, 4'b0000}));
        vy = (r_sd[QB].yneg ? -$signed({2'b00, r_qy[QB]}) : $signed({2'b00, r_qy[QB]}))
           + $signed(VW'({i_cfg.center_y, 4'b0000}));
        sx = sat(vx, hx);
        sy = sat(vy, hy);
        if (r_sd[QB].bad || r_sd[QB].ovx) begin
            sx = r_sd[QB].xneg ? SCR_MIN : SCR_MAX;
            hx = 1'b1;
        end
        if (r_sd[QB].bad || r_sd[QB].ovy) begin
            sy = r_sd[QB].yneg ? SCR_MIN : SCR_MAX;
            hy = 1'b1;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= r_sv[QB];
        end
        if (o_adv) begin
            r_sx   <= sx;
            r_sy   <= sy;
            r_clip <= hx || hy;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.screen_x = r_sx;
    assign o_result.screen_y = r_sy;
    assign o_result.clipped  = r_clip;

endmodule
`default_nettype wire

### hdl/vertex_rotate_project_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_rotate_project_top: vertex rotate and project engine
// Rotates vertices by three frame angles and maps them to screen pixels,
// with optional perspective divide.
// ----------------------------------------------------------------------------
//  channel    dir   payload                               transfer
//  i_item     in    operation, vertex_x/y/z               valid && ready
//  o_result   out   screen_x, screen_y, clipped           valid && ready
//  i_cfg_*    in    register index, write data            write enable
//
//  One item per clock sustained while the result sink is ready; a tick gives no result.
//  A vertex passes in order through the trig and rotation pipeline,
//  divisor and dividend setup, the one-bit-per-stage divider
//  and the output register.
//  A four-entry queue after the intake lets ticks and vertices transfer
//  while the back pipeline is stalled by the result sink, until the queue is full.
//  Reset is synchronous; it clears angles, valids and the queue, and
//  loads the register defaults.
// ----------------------------------------------------------------------------
module vertex_rotate_project_top #(
    parameter int COORD_FRAC_BITS = 14,
    parameter int TRIG_FRAC_BITS  = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    vrp_in_if.sink                            i_item,
    vrp_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vrp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import vrp_pkg::*;

    t_cfg  r_cfg;
    t_item w_push_item, w_pop_item;
    logic  w_push, w_pop, w_full, w_empty, w_adv, w_rot_valid;
    logic signed [ROT_W-1:0] w_rx, w_ry, w_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_scale   <= RST_SCREEN_SCALE;
            r_cfg.center_x       <= RST_CENTER_X;
            r_cfg.center_y       <= RST_CENTER_Y;
            r_cfg.view_distance  <= RST_VIEW_DISTANCE;
            r_cfg.perspective_on <= 1'b1;
            r_cfg.step_x         <= RST_STEP;
            r_cfg.step_y         <= RST_STEP;
            r_cfg.step_z         <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCREEN_SCALE:   r_cfg.screen_scale   <= i_cfg_data[SCALE_W-1:0];
                REG_CENTER_X:       r_cfg.center_x       <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:       r_cfg.center_y       <= i_cfg_data[CENTER_W-1:0];
                REG_VIEW_DISTANCE:  r_cfg.view_distance  <= i_cfg_data[DIST_W-1:0];
                REG_PERSPECTIVE_ON: r_cfg.perspective_on <= i_cfg_data[0];
                REG_STEP_X:         r_cfg.step_x         <= i_cfg_data[ANG_W-1:0];
                REG_STEP_Y:         r_cfg.step_y         <= i_cfg_data[ANG_W-1:0];
                REG_STEP_Z:         r_cfg.step_z         <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    vrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    vrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_pop_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    vrp_rotate #(
        .TF (TRIG_FRAC_BITS)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (!w_empty),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .o_valid (w_rot_valid),
        .o_x     (w_rx),
        .o_y     (w_ry),
        .o_z     (w_rz)
    );

    vrp_project #(
        .CF (COORD_FRAC_BITS)
    ) u_project (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_rot_valid),
        .i_x      (w_rx),
        .i_y      (w_ry),
        .i_z      (w_rz),
        .i_cfg    (r_cfg),
        .o_result (o_result),
        .o_adv    (w_adv)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");

    a_pop_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_adv)
        else $error("queue popped while back pipeline stalled");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> o_result.valid)
        else $error("back pipeline stalled with no result waiting");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_empty)
        else $error("queued vertex lost");

endmodule
`default_nettype wire
